// ===== rtl/gms_pkg.sv =====
package gms_pkg;

   localparam int JOINT_COUNT_DEF  = 6;
   localparam int TABLE_POINTS_DEF = 6;
   localparam int TABLE_COUNT      = 27;
   localparam int DUR_W            = 24;
   localparam int MOVE_W           = 26;
   localparam int PROG_W           = 18;
   localparam int ANG_W            = 16;
   localparam int ELAPSED_W        = 20;
   localparam int STATE_W          = 4;
   localparam int TAB_IDX_W        = 5;
   localparam int CSR_IDX_W        = 2;

   localparam logic [PROG_W-1:0] END_LIMIT = 18'd81920;
   localparam logic [PROG_W-1:0] PROG_MAX  = 18'h3FFFF;
   localparam logic [PROG_W-1:0] ONE_Q16   = 18'd65536;
   localparam logic [MOVE_W-1:0] MOVE_MAX  = 26'h3FFFFFF;

   localparam logic [DUR_W-1:0] SIT_STAND_RESET = 24'd1500000;
   localparam logic [DUR_W-1:0] STEP_RESET      = 24'd2000000;
   localparam logic [DUR_W-1:0] HOLD_RESET      = 24'd10000000;

   localparam logic [CSR_IDX_W-1:0] CSR_SIT_STAND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 2'd2;

   localparam logic [STATE_W-1:0] ST_INIT       = 4'd0;
   localparam logic [STATE_W-1:0] ST_STANDING   = 4'd1;
   localparam logic [STATE_W-1:0] ST_SITTING    = 4'd2;
   localparam logic [STATE_W-1:0] ST_STAND_UP   = 4'd3;
   localparam logic [STATE_W-1:0] ST_SIT_DOWN   = 4'd4;
   localparam logic [STATE_W-1:0] ST_FIRST_LEFT = 4'd5;
   localparam logic [STATE_W-1:0] ST_LEFT_FWD   = 4'd6;
   localparam logic [STATE_W-1:0] ST_STEP_RIGHT = 4'd7;
   localparam logic [STATE_W-1:0] ST_RIGHT_FWD  = 4'd8;
   localparam logic [STATE_W-1:0] ST_STEP_LEFT  = 4'd9;
   localparam logic [STATE_W-1:0] ST_LAST_RIGHT = 4'd10;
   localparam logic [STATE_W-1:0] ST_LAST_LEFT  = 4'd11;
   localparam logic [STATE_W-1:0] ST_ERROR      = 4'd12;

   typedef struct packed {
      logic                 red_level;
      logic                 blue_level;
      logic                 green_level;
      logic                 yellow_level;
      logic [ELAPSED_W-1:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] motion_state;
      logic [ANG_W-1:0]   left_knee_deg;
      logic [ANG_W-1:0]   right_knee_deg;
      logic [ANG_W-1:0]   left_hip_deg;
      logic [ANG_W-1:0]   right_hip_deg;
      logic [ANG_W-1:0]   left_ankle_deg;
      logic [ANG_W-1:0]   right_ankle_deg;
      logic               setpoint_update;
      logic               drives_enabled;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch request, compute next state
      logic div_start;    // clear divider for new quotient
      logic div_step;     // one restoring divide step
      logic finish;       // saturate progress, advance time
      logic interp_mul;   // product stage for current joint
      logic interp_wr;    // write setpoint of current joint
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_motion;
      logic green;
   } dp_sts_type;

   function automatic logic is_motion_state(input logic [STATE_W-1:0] s);
      return s == ST_SITTING || s == ST_STAND_UP || s == ST_SIT_DOWN ||
             s == ST_FIRST_LEFT || s == ST_STEP_RIGHT || s == ST_STEP_LEFT ||
             s == ST_LAST_RIGHT || s == ST_LAST_LEFT;
   endfunction

   // table index for each state and joint (left knee .. right ankle)
   function automatic logic [TAB_IDX_W-1:0] table_of(input logic [STATE_W-1:0] s,
                                                     input logic [2:0] j);
      logic [TAB_IDX_W-1:0] r;
      logic [4:0] b;
      logic [4:0] o;
      r = '0;
      unique case (s)
         ST_SITTING:    r = 5'(j >> 1);
         ST_STAND_UP:   r = 5'(6 + (j >> 1));
         ST_SIT_DOWN:   r = 5'(3 + (j >> 1));
         default: begin
            priority if (s == ST_FIRST_LEFT) begin
               b = 5'd9;  o = 5'd12;
            end else if (s == ST_STEP_RIGHT) begin
               b = 5'd15; o = 5'd18;
            end else if (s == ST_STEP_LEFT) begin
               b = 5'd18; o = 5'd15;
            end else if (s == ST_LAST_RIGHT) begin
               b = 5'd21; o = 5'd24;
            end else begin
               b = 5'd24; o = 5'd21;
            end
            r = (j[0] ? o : b) + 5'(j >> 1);
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] angle_of(input logic [TAB_IDX_W-1:0] t,
                                           input logic [3:0] p);
      logic [7:0] row [0:5];
      logic [2:0] k;
      k = (p > 4'd5) ? 3'd5 : p[2:0];
      unique case (t)
         5'd0:  row = '{80, 80, 80, 80, 80, 80};
         5'd1:  row = '{105, 105, 105, 105, 105, 105};
         5'd2:  row = '{100, 100, 100, 100, 100, 100};
         5'd3:  row = '{8, 15, 30, 54, 72, 80};
         5'd4:  row = '{170, 165, 150, 125, 110, 105};
         5'd5:  row = '{85, 85, 85, 85, 100, 100};
         5'd6:  row = '{80, 72, 54, 30, 15, 8};
         5'd7:  row = '{105, 110, 125, 150, 165, 170};
         5'd8:  row = '{100, 100, 85, 85, 85, 85};
         5'd9:  row = '{8, 50, 80, 80, 41, 25};
         5'd10: row = '{170, 140, 130, 120, 120, 150};
         5'd11: row = '{85, 90, 90, 90, 90, 100};
         5'd12: row = '{8, 8, 8, 8, 8, 8};
         5'd13: row = '{170, 170, 170, 170, 175, 180};
         5'd14: row = '{85, 90, 90, 90, 80, 80};
         5'd15: row = '{25, 8, 8, 8, 8, 8};
         5'd16: row = '{150, 160, 170, 170, 180, 180};
         5'd17: row = '{100, 90, 90, 90, 80, 80};
         5'd18: row = '{8, 2, 40, 80, 90, 25};
         5'd19: row = '{180, 180, 180, 140, 120, 150};
         5'd20: row = '{80, 110, 100, 90, 90, 100};
         5'd21: row = '{25, 8, 8, 8, 8, 8};
         5'd22: row = '{150, 170, 170, 170, 170, 170};
         5'd23: row = '{100, 90, 90, 90, 90, 85};
         5'd24: row = '{8, 8, 40, 80, 40, 8};
         5'd25: row = '{180, 185, 170, 130, 130, 170};
         5'd26: row = '{80, 90, 90, 90, 90, 85};
         default: row = '{0, 0, 0, 0, 0, 0};
      endcase
      return row[k];
   endfunction

endpackage

// ===== rtl/gms_datapath.sv =====
module gms_datapath #(
   parameter int JOINT_COUNT  = gms_pkg::JOINT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gms_pkg::req_type      req_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   input  gms_pkg::dp_cmd_type   cmd,
   input  logic [2:0]            joint_sel,
   output gms_pkg::dp_sts_type   sts,
   output gms_pkg::rsp_type      result
);
   localparam int DW = gms_pkg::DUR_W;
   localparam int MW = gms_pkg::MOVE_W;
   localparam int PW = gms_pkg::PROG_W;
   localparam int QW = MW + 16;   // full quotient width

   // interpolation mode of the current joint
   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_LAST  = 2'd1;
   localparam logic [1:0] MODE_BLEND = 2'd2;

   logic [DW-1:0] sit_stand_ff, step_ff, hold_ff;
   logic [3:0]    state_ff, state_in;
   logic [MW-1:0] move_ff;
   logic [PW-1:0] prog_ff;
   logic          enable_ff;
   logic          green_ff, entered_ff;
   logic [gms_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic [gms_pkg::ANG_W-1:0] held_ff [0:5];
   logic          update_ff;

   // restoring divider: quotient bits shift in, dividend bits shift out
   logic [QW-1:0] quo_ff;
   logic [DW:0]   rem_ff;
   logic [QW-1:0] dvd_ff;
   logic [DW-1:0] dur_ff;

   logic r, b, g, y, endf;
   assign r = ~req_data.red_level;
   assign b = ~req_data.blue_level;
   assign g = ~req_data.green_level;
   assign y = ~req_data.yellow_level;
   assign endf = prog_ff > gms_pkg::END_LIMIT;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gms_pkg::ST_INIT:
            if (b && !r && y && !g) state_in = gms_pkg::ST_SITTING;
         gms_pkg::ST_STANDING:
            if (y) state_in = gms_pkg::ST_SIT_DOWN;
            else if (b) state_in = gms_pkg::ST_FIRST_LEFT;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_SITTING:
            if (y) state_in = gms_pkg::ST_STAND_UP;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_STAND_UP, gms_pkg::ST_LAST_RIGHT, gms_pkg::ST_LAST_LEFT:
            if (endf) state_in = gms_pkg::ST_STANDING;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_SIT_DOWN:
            if (endf) state_in = gms_pkg::ST_SITTING;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_FIRST_LEFT, gms_pkg::ST_STEP_LEFT:
            if (endf) state_in = gms_pkg::ST_LEFT_FWD;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_LEFT_FWD:
            if (b) state_in = gms_pkg::ST_STEP_RIGHT;
            else if (y) state_in = gms_pkg::ST_LAST_RIGHT;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_STEP_RIGHT:
            if (endf) state_in = gms_pkg::ST_RIGHT_FWD;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_RIGHT_FWD:
            if (b) state_in = gms_pkg::ST_STEP_LEFT;
            else if (y) state_in = gms_pkg::ST_LAST_LEFT;
            else if (r) state_in = gms_pkg::ST_ERROR;
         gms_pkg::ST_ERROR:
            if (!b && r && !y && g) state_in = gms_pkg::ST_INIT;
         default: state_in = state_ff;
      endcase
   end

   logic          chg, new_motion;
   logic [DW-1:0] dur_sel;
   logic [MW-1:0] move_cap;
   assign chg        = state_in != state_ff;
   assign new_motion = gms_pkg::is_motion_state(state_in);
   assign move_cap   = (chg && new_motion) ? '0 : move_ff;

   always_comb begin
      if (state_in == gms_pkg::ST_SITTING) dur_sel = hold_ff;
      else if (state_in == gms_pkg::ST_STAND_UP || state_in == gms_pkg::ST_SIT_DOWN)
         dur_sel = sit_stand_ff;
      else dur_sel = step_ff;
      if (dur_sel == '0) dur_sel = DW'(1);
   end

   logic [DW:0] rem_shift, rem_sub;
   assign rem_shift = {rem_ff[DW-1:0], dvd_ff[QW-1]};
   assign rem_sub   = rem_shift - {1'b0, dur_ff};

   // interpolation: x = prog * (points-1); i = x>>16, f = low 16 bits
   localparam int SEG = gms_pkg::TABLE_POINTS_DEF - 1;
   localparam int XW  = PW + 4;
   logic [XW-1:0] x_val;
   logic [3:0]    seg_i;
   logic [15:0]   frac;
   logic [gms_pkg::TAB_IDX_W-1:0] tab;
   logic [7:0]    p0, p1, plast;
   logic signed [25:0] prod_in, prod_ff;
   logic [7:0]    p0_ff;
   logic [1:0]    mode_ff, mode_in;
   logic [7:0]    plast_ff;
   logic signed [26:0] acc;
   logic [gms_pkg::ANG_W-1:0] angle;

   assign x_val = XW'(prog_ff) * XW'(SEG);
   assign seg_i = x_val[19:16];
   assign frac  = x_val[15:0];
   assign tab   = gms_pkg::table_of(state_ff, joint_sel);
   assign p0    = gms_pkg::angle_of(tab, seg_i);
   assign p1    = gms_pkg::angle_of(tab, seg_i + 4'd1);
   assign plast = gms_pkg::angle_of(tab, 4'(SEG));
   assign prod_in = $signed({10'd0, frac}) * ($signed({1'b0, p1}) - $signed({1'b0, p0}));

   always_comb begin
      if (prog_ff == '0) mode_in = MODE_FIRST;
      else if (prog_ff >= gms_pkg::ONE_Q16 || seg_i >= 4'(SEG)) mode_in = MODE_LAST;
      else mode_in = MODE_BLEND;
   end

   assign acc = $signed({3'd0, p0_ff, 16'd0}) + 27'(prod_ff);
   always_comb begin
      unique case (mode_ff)
         MODE_FIRST: angle = {p0_ff, 8'd0};
         MODE_LAST:  angle = {plast_ff, 8'd0};
         default:    angle = acc[26] ? '0 : acc[23:8];
      endcase
   end

   logic [MW:0] move_sum;
   assign move_sum = {1'b0, move_ff} + (MW+1)'(elapsed_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sit_stand_ff <= gms_pkg::SIT_STAND_RESET;
         step_ff      <= gms_pkg::STEP_RESET;
         hold_ff      <= gms_pkg::HOLD_RESET;
         state_ff     <= gms_pkg::ST_INIT;
         move_ff      <= '0;
         prog_ff      <= '0;
         enable_ff    <= 1'b0;
         update_ff    <= 1'b0;
         for (int k = 0; k < 6; k++) held_ff[k] <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               gms_pkg::CSR_SIT_STAND: sit_stand_ff <= csr_wdata;
               gms_pkg::CSR_STEP:      step_ff      <= csr_wdata;
               gms_pkg::CSR_HOLD:      hold_ff      <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.capture) begin
            state_ff   <= state_in;
            move_ff    <= move_cap;
            if (chg && new_motion) prog_ff <= '0;
            if (chg && state_ff == gms_pkg::ST_INIT) enable_ff <= 1'b1;
            if (chg && state_in == gms_pkg::ST_ERROR) enable_ff <= 1'b0;
            green_ff   <= g;
            entered_ff <= chg && new_motion;
            elapsed_ff <= req_data.elapsed_us;
            dur_ff     <= dur_sel;
            dvd_ff     <= {move_cap, 16'd0};
            update_ff  <= 1'b0;
         end
         if (cmd.div_start) begin
            quo_ff <= '0;
            rem_ff <= '0;
         end else if (cmd.div_step) begin
            dvd_ff <= dvd_ff << 1;
            if (!rem_sub[DW]) begin
               rem_ff <= rem_sub;
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
         end
         if (cmd.finish) begin
            prog_ff <= (quo_ff > QW'(gms_pkg::PROG_MAX)) ? gms_pkg::PROG_MAX : quo_ff[PW-1:0];
            if (green_ff) begin
               update_ff <= 1'b1;
               if (!entered_ff)
                  move_ff <= move_sum[MW] ? gms_pkg::MOVE_MAX : move_sum[MW-1:0];
            end
         end
         if (cmd.interp_mul) begin
            prod_ff  <= prod_in;
            p0_ff    <= p0;
            plast_ff <= plast;
            mode_ff  <= mode_in;
         end
         if (cmd.interp_wr && 32'(joint_sel) < JOINT_COUNT) held_ff[joint_sel] <= angle;
      end
   end

   assign sts.is_motion = gms_pkg::is_motion_state(state_ff);
   assign sts.green     = green_ff;

   assign result.motion_state    = state_ff;
   assign result.left_knee_deg   = held_ff[0];
   assign result.right_knee_deg  = held_ff[1];
   assign result.left_hip_deg    = held_ff[2];
   assign result.right_hip_deg   = held_ff[3];
   assign result.left_ankle_deg  = held_ff[4];
   assign result.right_ankle_deg = held_ff[5];
   assign result.setpoint_update = update_ff;
   assign result.drives_enabled  = enable_ff;
endmodule

// ===== rtl/gms_control.sv =====
module gms_control #(
   parameter int JOINT_COUNT = gms_pkg::JOINT_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  gms_pkg::dp_sts_type sts,
   output gms_pkg::dp_cmd_type cmd,
   output logic [2:0]          joint_sel
);
   localparam int QW = gms_pkg::MOVE_W + 16;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] j_ff, j_in;
   logic       accept;

   assign req_stall = st_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = st_ff == S_OUT;
   assign joint_sel = j_ff;

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      j_in   = j_ff;
      cmd    = '0;
      unique case (st_ff)
         S_IDLE: if (accept) begin
            cmd.capture   = 1'b1;
            cmd.div_start = 1'b1;
            cnt_in = '0;
            st_in  = S_DIV;
         end
         S_DIV: begin
            if (!sts.is_motion) st_in = S_OUT;
            else begin
               cmd.div_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'(QW - 1)) st_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            j_in  = '0;
            st_in = sts.green ? S_MUL : S_OUT;
         end
         S_MUL: begin
            cmd.interp_mul = 1'b1;
            st_in = S_WR;
         end
         S_WR: begin
            cmd.interp_wr = 1'b1;
            j_in = j_ff + 3'd1;
            st_in = (32'(j_ff) == JOINT_COUNT - 1) ? S_OUT : S_MUL;
         end
         S_OUT: if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
         j_ff   <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         j_ff   <= j_in;
      end
   end
endmodule

// ===== rtl/gait_motion_sequencer.sv =====
// Gait motion sequencer. Each req_ beat is one control tick (four active-low
// buttons plus elapsed microseconds) and yields exactly one rsp_ beat with the
// state, six Q8.8 joint setpoints, an update flag and the drive enable. Items
// are handled one at a time. A tick in a motion state with green held passes
// through a capture step, the 42-step bit-serial divider that forms progress
// (moving time over duration), a finish step, a multiply step and a write step
// per joint for the interpolation, then the output state and the return to
// idle. With green released the joints are skipped; a tick in a resting state
// skips the divider and the joints. The result is held on rsp_ until taken.
// Durations are to be written through csr_ only while the block is idle; the
// block itself does not enforce this.
module gait_motion_sequencer #(
   parameter int JOINT_COUNT  = gms_pkg::JOINT_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gms_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   gms_pkg::dp_cmd_type cmd;
   gms_pkg::dp_sts_type sts;
   logic [2:0]          joint_sel;

   // the user must write registers only between ticks; the block does not enforce this
   assign csr_ready = 1'b1;

   gms_control #(.JOINT_COUNT(JOINT_COUNT)) u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd, .joint_sel
   );

   gms_datapath #(.JOINT_COUNT(JOINT_COUNT)) u_dp (
      .clock, .reset, .req_data, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .cmd, .joint_sel, .sts, .result(rsp_data)
   );
endmodule
